[hdl/far_pkg.sv]
// Shared constants and types for the fraction arithmetic and reduction block.
`default_nettype none
package far_pkg;

   localparam int OPCODE_W = 3;
   typedef logic [OPCODE_W-1:0] opcode_type;

   localparam opcode_type OP_ADD      = 3'd0;
   localparam opcode_type OP_SUB      = 3'd1;
   localparam opcode_type OP_MUL      = 3'd2;
   localparam opcode_type OP_DIV      = 3'd3;
   localparam opcode_type OP_SIMPLIFY = 3'd4;

   localparam int RESULT_NUM_W = 33;
   localparam int RESULT_DEN_W = 32;

   // intermediate values wrap at no more than this width
   localparam int WRAP_W = 64;

   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_LANES   = 2;

endpackage
`default_nettype wire

[hdl/far_front.sv]
// Front end: accepts items, selects operand pairs by opcode, forms products and sum or difference.
`default_nettype none
module far_front #(
   parameter int OPERAND_WIDTH = 16,
   parameter int CALC_W        = 33
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   output logic                                 full,
   input  wire far_pkg::opcode_type             opcode,
   input  wire logic signed [OPERAND_WIDTH-1:0] first_numerator,
   input  wire logic signed [OPERAND_WIDTH-1:0] first_denominator,
   input  wire logic signed [OPERAND_WIDTH-1:0] second_numerator,
   input  wire logic signed [OPERAND_WIDTH-1:0] second_denominator,
   output logic                                 q_push,
   input  wire logic                            q_full,
   output logic signed [CALC_W-1:0]             q_num,
   output logic signed [CALC_W-1:0]             q_den
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   localparam int W = OPERAND_WIDTH;
   localparam logic signed [W-1:0] ONE = W'(1);

   logic [1:0] state_ff, state_in;

   logic signed [W-1:0] a0_in, b0_in, a1_in, b1_in, a2_in, b2_in;
   logic signed [W-1:0] a0_ff, b0_ff, a1_ff, b1_ff, a2_ff, b2_ff;
   logic                sub_in, sub_ff;

   logic signed [2*W-1:0]    prod0, prod1, prod2;
   logic signed [CALC_W-1:0] p0_ff, p1_ff, p2_ff;

   logic accept;

   assign full   = (state_ff != ST_IDLE);
   assign accept = push && !full;

   always_comb begin
      a0_in  = first_numerator;
      b0_in  = second_denominator;
      a1_in  = '0;
      b1_in  = '0;
      a2_in  = first_denominator;
      b2_in  = second_denominator;
      sub_in = 1'b0;
      case (opcode)
         far_pkg::OP_ADD: begin
            a1_in = second_numerator;
            b1_in = first_denominator;
         end
         far_pkg::OP_SUB: begin
            a1_in  = second_numerator;
            b1_in  = first_denominator;
            sub_in = 1'b1;
         end
         far_pkg::OP_MUL: begin
            b0_in = second_numerator;
         end
         far_pkg::OP_DIV: begin
            b2_in = second_numerator;
         end
         far_pkg::OP_SIMPLIFY: begin
            b0_in = ONE;
            b2_in = ONE;
         end
         default: begin
            a0_in = '0;
            b0_in = '0;
            a2_in = ONE;
            b2_in = ONE;
         end
      endcase
   end

   assign prod0 = a0_ff * b0_ff;
   assign prod1 = a1_ff * b1_ff;
   assign prod2 = a2_ff * b2_ff;

   assign q_push = (state_ff == ST_PUSH) && !q_full;
   assign q_num  = sub_ff ? (p0_ff - p1_ff) : (p0_ff + p1_ff);
   assign q_den  = p2_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_MUL;
         ST_MUL:  state_in = ST_PUSH;
         ST_PUSH: if (!q_full) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a0_ff  <= a0_in;
         b0_ff  <= b0_in;
         a1_ff  <= a1_in;
         b1_ff  <= b1_in;
         a2_ff  <= a2_in;
         b2_ff  <= b2_in;
         sub_ff <= sub_in;
      end
      if (state_ff == ST_MUL) begin
         p0_ff <= CALC_W'(prod0);
         p1_ff <= CALC_W'(prod1);
         p2_ff <= CALC_W'(prod2);
      end
   end

endmodule
`default_nettype wire

[hdl/far_queue.sv]
// Short first-word-fall-through queue between front and back.
`default_nettype none
module far_queue #(
   parameter int DATA_W = 66
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic              pop,
   output logic                   empty,
   output logic [DATA_W-1:0]      rdata
);

   localparam int DEPTH = far_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= wdata;
   end

endmodule
`default_nettype wire

[hdl/far_gcd.sv]
// Binary GCD unit, one shift or subtract per cycle.
`default_nettype none
module far_gcd #(
   parameter int CALC_W = 33
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [CALC_W-1:0] a_start,
   input  wire logic [CALC_W-1:0] b_start,
   output logic                   done,
   output logic [CALC_W-1:0]      gcd
);

   localparam int K_W = $clog2(CALC_W);

   logic              run_ff, run_in, done_ff, done_in;
   logic [CALC_W-1:0] a_ff, a_in, b_ff, b_in, g_ff;
   logic [K_W-1:0]    k_ff, k_in;
   logic              finish;

   assign done   = done_ff;
   assign gcd    = g_ff;
   assign finish = run_ff && (a_ff == '0);

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      run_in  = run_ff;
      done_in = finish;
      if (start) begin
         a_in   = a_start;
         b_in   = b_start;
         k_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (finish) begin
            run_in = 1'b0;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + K_W'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
      if (finish) g_ff <= b_ff << k_ff;
   end

endmodule
`default_nettype wire

[hdl/far_div.sv]
// Restoring divider, one quotient bit per cycle, lanes sharing one divisor.
`default_nettype none
module far_div #(
   parameter int CALC_W = 33
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          start,
   input  wire logic [far_pkg::DIV_LANES-1:0][CALC_W-1:0]     dividend,
   input  wire logic [CALC_W-1:0]                             divisor,
   output logic                                               done,
   output logic [far_pkg::DIV_LANES-1:0][CALC_W-1:0]          quotient
);

   localparam int LANES = far_pkg::DIV_LANES;
   localparam int CNT_W = $clog2(CALC_W + 1);

   logic                               run_ff, run_in, done_ff, done_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [CALC_W-1:0]                  div_ff;
   logic [LANES-1:0][CALC_W-1:0]       rem_ff, rem_in, quo_ff, quo_in;
   logic [LANES-1:0][CALC_W:0]         trial;
   logic [LANES-1:0]                   fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         trial[i]  = {rem_ff[i], quo_ff[i][CALC_W-1]};
         fits[i]   = (trial[i] >= {1'b0, div_ff});
         rem_in[i] = fits[i] ? CALC_W'(trial[i] - {1'b0, div_ff}) : CALC_W'(trial[i]);
         quo_in[i] = {quo_ff[i][CALC_W-2:0], fits[i]};
      end
   end

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(CALC_W);
      end else if (run_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule
`default_nettype wire

[hdl/far_back.sv]
// Back end: reduces each queued fraction with a positive denominator above one by its GCD and holds the result item.
`default_nettype none
module far_back #(
   parameter int CALC_W = 33
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    q_empty,
   output logic                                         q_pop,
   input  wire logic [2*CALC_W-1:0]                     q_data,
   input  wire logic                                    pop,
   output logic                                         empty,
   output logic signed [far_pkg::RESULT_NUM_W-1:0]      result_numerator,
   output logic signed [far_pkg::RESULT_DEN_W-1:0]      result_denominator
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_GCD    = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [CALC_W-1:0] head_num, head_den, head_mag;
   logic              head_neg, head_reduce;

   logic [CALC_W-1:0] num_ff, den_ff, mag_ff;
   logic              neg_ff;

   logic                                       gcd_start, gcd_done;
   logic [CALC_W-1:0]                          gcd_val;
   logic                                       div_start, div_done;
   logic [far_pkg::DIV_LANES-1:0][CALC_W-1:0]  div_dividend, div_quotient;

   logic out_free, out_load;
   logic out_valid_ff, out_valid_in;
   logic signed [far_pkg::RESULT_NUM_W-1:0] out_num_ff;
   logic signed [far_pkg::RESULT_DEN_W-1:0] out_den_ff;

   assign head_num    = q_data[2*CALC_W-1:CALC_W];
   assign head_den    = q_data[CALC_W-1:0];
   assign head_neg    = head_num[CALC_W-1];
   assign head_mag    = head_neg ? (CALC_W'(0) - head_num) : head_num;
   assign head_reduce = !head_den[CALC_W-1] && (head_den > CALC_W'(1));

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign gcd_start = q_pop && head_reduce;
   assign div_start = (state_ff == ST_GCD) && gcd_done && (gcd_val != CALC_W'(1));

   assign div_dividend[0] = mag_ff;
   assign div_dividend[1] = den_ff;

   far_gcd #(.CALC_W(CALC_W)) u_gcd (
      .clock   (clock),
      .reset   (reset),
      .start   (gcd_start),
      .a_start (head_mag),
      .b_start (head_den),
      .done    (gcd_done),
      .gcd     (gcd_val)
   );

   far_div #(.CALC_W(CALC_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gcd_val),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign out_free = !out_valid_ff || pop;
   assign out_load = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (q_pop) state_in = head_reduce ? ST_GCD : ST_FINISH;
         ST_GCD:    if (gcd_done) state_in = div_start ? ST_DIV : ST_FINISH;
         ST_DIV:    if (div_done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         num_ff <= head_num;
         den_ff <= head_den;
         mag_ff <= head_mag;
         neg_ff <= head_neg;
      end else if ((state_ff == ST_DIV) && div_done) begin
         num_ff <= neg_ff ? (CALC_W'(0) - div_quotient[0]) : div_quotient[0];
         den_ff <= div_quotient[1];
      end
      if (out_load) begin
         out_num_ff <= far_pkg::RESULT_NUM_W'($signed(num_ff));
         out_den_ff <= far_pkg::RESULT_DEN_W'($signed(den_ff));
      end
   end

   assign empty              = !out_valid_ff;
   assign result_numerator   = out_num_ff;
   assign result_denominator = out_den_ff;

endmodule
`default_nettype wire

[hdl/fraction_arith_reduce.sv]
// Top level of the fraction arithmetic and GCD reduction block.
//
//  channel   ports                                         handshake
//  request   req_opcode, req_first_*, req_second_*         push / full
//  response  rsp_result_numerator, rsp_result_denominator  empty / pop
//
// The front end registers the selected operands, then the products, and pushes
// the sum or difference into a two-entry queue before it takes the next item.
// The back end dequeues an item, runs the binary GCD loop and, if needed, the
// CALC_W-bit divider (CALC_W = 33 by default), then loads the output register.
// Reset is synchronous and empties the front, the queue and the output register.
// Either side may stall: the queue and the output register decouple the stages.
`default_nettype none
module fraction_arith_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   push,
   output logic                                        full,
   input  wire far_pkg::opcode_type                    req_opcode,
   input  wire logic signed [OPERAND_WIDTH-1:0]        req_first_numerator,
   input  wire logic signed [OPERAND_WIDTH-1:0]        req_first_denominator,
   input  wire logic signed [OPERAND_WIDTH-1:0]        req_second_numerator,
   input  wire logic signed [OPERAND_WIDTH-1:0]        req_second_denominator,
   output logic                                        empty,
   input  wire logic                                   pop,
   output logic signed [far_pkg::RESULT_NUM_W-1:0]     rsp_result_numerator,
   output logic signed [far_pkg::RESULT_DEN_W-1:0]     rsp_result_denominator
);

   localparam int CALC_W = (2*OPERAND_WIDTH + 1 > far_pkg::WRAP_W) ?
                           far_pkg::WRAP_W : 2*OPERAND_WIDTH + 1;

   logic                     fq_push, fq_full, bq_pop, bq_empty;
   logic signed [CALC_W-1:0] fq_num, fq_den;
   logic [2*CALC_W-1:0]      bq_data;

   far_front #(
      .OPERAND_WIDTH (OPERAND_WIDTH),
      .CALC_W        (CALC_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .opcode             (req_opcode),
      .first_numerator    (req_first_numerator),
      .first_denominator  (req_first_denominator),
      .second_numerator   (req_second_numerator),
      .second_denominator (req_second_denominator),
      .q_push             (fq_push),
      .q_full             (fq_full),
      .q_num              (fq_num),
      .q_den              (fq_den)
   );

   far_queue #(.DATA_W(2*CALC_W)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fq_push),
      .full  (fq_full),
      .wdata ({fq_num, fq_den}),
      .pop   (bq_pop),
      .empty (bq_empty),
      .rdata (bq_data)
   );

   far_back #(.CALC_W(CALC_W)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (bq_empty),
      .q_pop              (bq_pop),
      .q_data             (bq_data),
      .pop                (pop),
      .empty              (empty),
      .result_numerator   (rsp_result_numerator),
      .result_denominator (rsp_result_denominator)
   );

endmodule
`default_nettype wire
